// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL, included by expression_tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/et_pkg.sv =====
`timescale 1ns / 1ps
package et_pkg;

  localparam int IndexWidthDefault = 16;
  localparam int QueueDepthDefault = 2;
  localparam int OutIndexWidth     = 16;
  localparam int MaxTokens         = 3;

  localparam logic [7:0] ChAt     = 8'h40;  // '@'
  localparam logic [7:0] ChA      = 8'h61;  // 'a'
  localparam logic [7:0] ChM      = 8'h6d;  // 'm'
  localparam logic [7:0] ChD      = 8'h64;  // 'd'
  localparam logic [7:0] ChU      = 8'h75;  // 'u'
  localparam logic [7:0] ChL      = 8'h6c;  // 'l'
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_OPERAND = 3'd1,
    MODE_NAME1   = 3'd2,
    MODE_NAME2   = 3'd3,
    MODE_SKIP    = 3'd4,
    MODE_ERROR   = 3'd5
  } scan_mode_e;

  typedef enum logic [2:0] {
    TOK_OPERAND = 3'd0,
    TOK_ADD     = 3'd1,
    TOK_MUL     = 3'd2,
    TOK_ERROR   = 3'd3,
    TOK_END     = 3'd4
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    tok_kind_e                  token_kind;
    logic [OutIndexWidth-1:0]   operand_index;
    logic                       index_overflow;
    logic                       index_empty;
    logic                       last_of_run;
  } out_item_t;

  // All tokens caused by one character; count is 1..3.
  typedef struct packed {
    logic [1:0]                 count;
    out_item_t [MaxTokens-1:0]  toks;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } head_t;

endpackage

// ===== rtl/et_front.sv =====
`timescale 1ns / 1ps
module et_front #(
  parameter int INDEX_WIDTH = et_pkg::IndexWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  et_pkg::in_item_t in_item_i,
  output logic             in_ready_o,
  input  logic             full_i,
  output logic             push_o,
  output et_pkg::bundle_t  bundle_o
);
  import et_pkg::*;

  scan_mode_e             mode_q, mode_d;
  logic                   mul_q, mul_d;
  logic [INDEX_WIDTH-1:0] acc_q, acc_d;
  logic                   dseen_q, dseen_d;
  logic                   ovf_q, ovf_d;

  logic                   accept;
  logic [7:0]             c;
  logic                   is_digit;
  logic                   is_sep;
  logic [3:0]             digit;
  logic [INDEX_WIDTH+3:0] acc_x10;
  logic                   sat;
  logic [INDEX_WIDTH-1:0] acc_step;
  logic                   name_hit;

  out_item_t [MaxTokens-1:0] toks;
  logic [1:0]                n;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_item_i.text_char;
  assign is_digit   = (c >= ChZero) && (c <= ChNine);
  assign is_sep     = (c == ChSpace) || (c == ChLParen) || (c == ChRParen) || (c == ChComma);
  assign digit      = 4'(c - ChZero);

  // acc*10 + digit by shift-add; saturate when the high bits are set
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                    {{INDEX_WIDTH{1'b0}}, digit};
  assign sat      = |acc_x10[INDEX_WIDTH+3:INDEX_WIDTH];
  assign acc_step = sat ? '1 : acc_x10[INDEX_WIDTH-1:0];

  // expected letter of the operator name in the current name position
  assign name_hit = (mode_q == MODE_NAME1) ? (c == (mul_q ? ChU : ChD)) :
                                             (c == (mul_q ? ChL : ChD));

  // next state
  always_comb begin
    logic do_idle;
    mode_d  = mode_q;
    mul_d   = mul_q;
    acc_d   = acc_q;
    dseen_d = dseen_q;
    ovf_d   = ovf_q;
    do_idle = 1'b0;

    unique case (mode_q)
      MODE_OPERAND: begin
        if (is_digit) begin
          dseen_d = 1'b1;
          acc_d   = acc_step;
          ovf_d   = ovf_q | sat;
        end else begin
          acc_d   = '0;
          dseen_d = 1'b0;
          ovf_d   = 1'b0;
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_NAME1: mode_d = name_hit ? MODE_NAME2 : MODE_ERROR;
      MODE_NAME2: mode_d = name_hit ? MODE_SKIP : MODE_ERROR;
      MODE_SKIP:  mode_d = MODE_IDLE;
      MODE_ERROR: mode_d = MODE_ERROR;
      default:    do_idle = 1'b1;
    endcase

    if (do_idle) begin
      if (c == ChAt) begin
        mode_d  = MODE_OPERAND;
        acc_d   = '0;
        dseen_d = 1'b0;
        ovf_d   = 1'b0;
      end else if (c == ChA) begin
        mode_d = MODE_NAME1;
        mul_d  = 1'b0;
      end else if (c == ChM) begin
        mode_d = MODE_NAME1;
        mul_d  = 1'b1;
      end else if (is_sep) begin
        mode_d = MODE_IDLE;
      end else begin
        mode_d = MODE_ERROR;
      end
    end

    if (in_item_i.end_of_text) begin
      mode_d  = MODE_IDLE;
      mul_d   = 1'b0;
      acc_d   = '0;
      dseen_d = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  // tokens caused by the current character
  always_comb begin
    logic idle_path;
    logic open_op;
    logic fresh_op;
    logic open_name;
    toks      = '0;
    n         = 2'd0;
    idle_path = 1'b0;
    open_op   = 1'b0;
    fresh_op  = 1'b0;
    open_name = 1'b0;

    unique case (mode_q)
      MODE_OPERAND: begin
        if (is_digit) begin
          open_op = 1'b1;
        end else begin
          toks[n].token_kind     = TOK_OPERAND;
          toks[n].operand_index  = OutIndexWidth'(acc_q);
          toks[n].index_overflow = ovf_q;
          toks[n].index_empty    = !dseen_q;
          n         = n + 2'd1;
          idle_path = 1'b1;
        end
      end
      MODE_NAME1: begin
        if (name_hit) begin
          open_name = 1'b1;
        end else begin
          toks[n].token_kind = TOK_ERROR;
          n = n + 2'd1;
        end
      end
      MODE_NAME2: begin
        toks[n].token_kind = !name_hit ? TOK_ERROR : (mul_q ? TOK_MUL : TOK_ADD);
        n = n + 2'd1;
      end
      MODE_SKIP, MODE_ERROR: begin
      end
      default: idle_path = 1'b1;
    endcase

    if (idle_path) begin
      if (c == ChAt) begin
        fresh_op = 1'b1;
      end else if (c == ChA || c == ChM) begin
        open_name = 1'b1;
      end else if (!is_sep) begin
        toks[n].token_kind = TOK_ERROR;
        n = n + 2'd1;
      end
    end

    if (in_item_i.end_of_text) begin
      if (open_op) begin
        toks[n].token_kind     = TOK_OPERAND;
        toks[n].operand_index  = OutIndexWidth'(acc_step);
        toks[n].index_overflow = ovf_q | sat;
        toks[n].index_empty    = 1'b0;
        n = n + 2'd1;
      end else if (fresh_op) begin
        toks[n].token_kind  = TOK_OPERAND;
        toks[n].index_empty = 1'b1;
        n = n + 2'd1;
      end else if (open_name) begin
        toks[n].token_kind = TOK_ERROR;
        n = n + 2'd1;
      end
      toks[n].token_kind = TOK_END;
      n = n + 2'd1;
    end

    for (int i = 0; i < MaxTokens; i++) begin
      toks[i].last_of_run = (n == 2'(i + 1));
    end
  end

  assign push_o   = accept && (n != 2'd0);
  assign bundle_o = {n, toks};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      mul_q   <= 1'b0;
      acc_q   <= '0;
      dseen_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      mul_q   <= mul_d;
      acc_q   <= acc_d;
      dseen_q <= dseen_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== rtl/et_queue.sv =====
`timescale 1ns / 1ps
module et_queue #(
  parameter int DEPTH = et_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  et_pkg::bundle_t push_data_i,
  output logic            full_o,
  output et_pkg::head_t   head_o,
  input  logic            pop_i
);
  import et_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bundle_t         slots_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = (cnt_q == CntW'(DEPTH));
  assign head_o = {(cnt_q != '0), slots_q[rd_q]};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/et_back.sv =====
`timescale 1ns / 1ps
module et_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  et_pkg::head_t     head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output et_pkg::out_item_t out_item_o
);
  import et_pkg::*;

  logic [1:0] sel_q;
  logic       take;
  logic       last_tok;

  assign out_valid_o = head_i.valid;
  assign out_item_o  = head_i.bundle.toks[sel_q];
  assign take        = out_valid_o && out_ready_i;
  assign last_tok    = (sel_q == head_i.bundle.count - 2'd1);
  assign pop_o       = take && last_tok;

  // walks the tokens of the head bundle, one per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 2'd0;
    end else if (take) begin
      sel_q <= last_tok ? 2'd0 : sel_q + 2'd1;
    end
  end

endmodule

// ===== rtl/expression_tokenizer.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// input     in   in_valid_i/in_ready_o   in_item_i   (text_char, end_of_text)
// output    out  out_valid_o/out_ready_i out_item_o  (token, index, flags, last)
//
// One character accepted per cycle while the token queue has room; the front
// decodes it in that cycle and queues the 0..3 tokens it causes as one entry.
// The back sends one token per cycle while out_ready_i is high.
// Reset returns the scanner to idle and empties the queue.
// Output stalls fill the queue; input stalls only when it is full.
module expression_tokenizer #(
  parameter int INDEX_WIDTH = et_pkg::IndexWidthDefault,
  parameter int QUEUE_DEPTH = et_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  et_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output et_pkg::out_item_t out_item_o
);
  import et_pkg::*;
`include "assert_macros.svh"

  logic    push;
  logic    full;
  logic    pop;
  bundle_t bundle;
  head_t   head;

  logic    eot_in;
  logic    end_out;
  logic    other_out;
  logic    other_clean;

  et_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  et_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (bundle),
    .full_o      (full),
    .head_o      (head),
    .pop_i       (pop)
  );

  et_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  assign eot_in      = in_valid_i && in_ready_o && in_item_i.end_of_text;
  assign end_out     = out_valid_o && (out_item_o.token_kind == TOK_END);
  assign other_out   = out_valid_o && (out_item_o.token_kind != TOK_OPERAND);
  assign other_clean = (out_item_o.operand_index == '0) && !out_item_o.index_overflow &&
                       !out_item_o.index_empty;

  `ET_ASSERT_NEXT(a_eot_yields_token, clk_i, rst_ni, eot_in, out_valid_o, "end of text lost")

  `ET_ASSERT_NOW(a_end_is_last, clk_i, rst_ni, end_out, out_item_o.last_of_run, "end not last")

  `ET_ASSERT_NOW(a_non_operand_clean, clk_i, rst_ni, other_out, other_clean, "stray index")

endmodule
